>>> rtl/twsg_pkg.sv
// Package for the table waveform sweep generator: request codes, shape tables,
// shared controller/datapath structs. No dependencies.
`default_nettype none
package twsg_pkg;
    localparam logic [1:0] REQ_STEP  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;
    localparam logic [1:0] REQ_WRITE = 2'd3;

    localparam logic [2:0] CFG_WAVE  = 3'd0;
    localparam logic [2:0] CFG_LEN   = 3'd1;
    localparam logic [2:0] CFG_AMP   = 3'd2;
    localparam logic [2:0] CFG_BASE  = 3'd3;
    localparam logic [2:0] CFG_HIGH  = 3'd4;
    localparam logic [2:0] CFG_STEP  = 3'd5;
    localparam logic [2:0] CFG_DWELL = 3'd6;
    localparam logic [2:0] CFG_CLOCK = 3'd7;

    localparam logic [2:0] WAVE_SINE   = 3'd0;
    localparam logic [2:0] WAVE_TRI    = 3'd1;
    localparam logic [2:0] WAVE_SQUARE = 3'd2;
    localparam logic [2:0] WAVE_SAW    = 3'd3;
    localparam logic [2:0] WAVE_USER   = 3'd4;

    localparam int unsigned PHASE_W   = 40;
    localparam int unsigned DIV_STEPS = 40;
    localparam logic [4:0]  BURST_MAX = 5'd16;
    localparam logic [16:0] FULL_CODE = 17'd65535;

    // datapath commands
    typedef struct packed {
        logic start;      // clear phase, index; load freq
        logic sweep;      // sweep tick step
        logic add;        // add phase increment
        logic div_start;  // start phase / clock division
        logic emit;       // advance sample index
        logic stop;
    } t_cmd;

    typedef struct packed {
        logic       ok;        // start check passed
        logic       running;
        logic       div_busy;
        logic [4:0] due;       // capped sample count
        logic       step_ok;   // elapsed and clock nonzero
    } t_stat;

    function automatic logic [15:0] shape_word(input logic [2:0] sel, input logic [3:0] k);
        logic [15:0] w;
        w = 16'd0;
        case (sel)
            WAVE_SINE: begin
                case (k)
                    4'd0: w = 16'd32768;  4'd1: w = 16'd45307;
                    4'd2: w = 16'd55938;  4'd3: w = 16'd63041;
                    4'd4: w = 16'd65535;  4'd5: w = 16'd63041;
                    4'd6: w = 16'd55938;  4'd7: w = 16'd45307;
                    4'd8: w = 16'd32768;  4'd9: w = 16'd20228;
                    4'd10: w = 16'd9597;  4'd11: w = 16'd2494;
                    4'd12: w = 16'd0;     4'd13: w = 16'd2494;
                    4'd14: w = 16'd9597;  default: w = 16'd20228;
                endcase
            end
            WAVE_TRI: begin
                if (k == 4'd8) w = 16'd65535;
                else if (k < 4'd8) w = {k[2:0], 13'd0};
                else w = {3'(4'd0 - k), 13'd0};
            end
            WAVE_SQUARE: w = k[3] ? 16'd65535 : 16'd0;
            default: w = 16'(k * 16'd4369);
        endcase
        return w;
    endfunction
endpackage
`default_nettype wire

>>> rtl/twsg_datapath.sv
// Datapath: config, sweep, phase accumulator, iterative divider, user table,
// sample scaling. Depends on twsg_pkg.
`default_nettype none
module twsg_datapath import twsg_pkg::*; #(
    parameter int TABLE_DEPTH     = 16,
    parameter int MAX_SAMPLE_RATE = 16000
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [29:0] i_cfg_data,
    input  wire logic        i_in_write,
    input  wire logic        i_ms_tick,
    input  wire logic [15:0] i_elapsed,
    input  wire logic [3:0]  i_entry_index,
    input  wire logic [15:0] i_entry_value,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    output logic [15:0]      o_dac_code
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = $clog2(TABLE_DEPTH + 1) + 14;

    logic [2:0]  r_wave;
    logic [4:0]  r_tlen;
    logic [15:0] r_amp;
    logic [13:0] r_base, r_high, r_step;
    logic [15:0] r_dwell;
    logic [29:0] r_clock;

    logic        r_running, r_sweeping, r_up;
    logic [13:0] r_hz;
    logic [15:0] r_dwell_cnt;
    logic [PHASE_W-1:0] r_phase;
    logic [IW-1:0] r_idx;
    logic [15:0] r_user [TABLE_DEPTH];
    logic [15:0] r_el;

    // divider
    logic [PHASE_W-1:0] r_quo;
    logic [30:0]        r_rem;
    logic [5:0]         r_cnt;
    logic               r_busy;
    logic               r_div_done;

    // effective length
    logic [LW-1:0] len;
    always_comb begin
        if (r_wave <= WAVE_SAW) len = LW'(TABLE_DEPTH);
        else if (r_tlen == 5'd0) len = LW'(1);
        else if (32'(r_tlen) > TABLE_DEPTH) len = LW'(TABLE_DEPTH);
        else len = LW'(r_tlen);
    end

    logic [CW-1:0] lb, lh;
    logic ok;
    assign lb = CW'(len) * CW'(r_base);
    assign lh = CW'(len) * CW'(r_high);
    always_comb begin
        ok = 1'b1;
        if (r_wave > WAVE_USER || r_clock == 30'd0 || r_base == 14'd0) ok = 1'b0;
        if (r_wave == WAVE_USER && (r_tlen == 5'd0 || 32'(r_tlen) > TABLE_DEPTH)) ok = 1'b0;
        if (32'(lb) > MAX_SAMPLE_RATE) ok = 1'b0;
        if (r_dwell != 16'd0) begin
            if (r_high <= r_base || r_step == 14'd0) ok = 1'b0;
            if (32'(lh) > MAX_SAMPLE_RATE) ok = 1'b0;
        end
    end

    // increment: elapsed * (len*hz); len*hz registered first
    logic [CW-1:0] r_lf;
    logic [CW+15:0] inc;
    assign inc = (CW+16)'(r_el) * (CW+16)'(r_lf);

    // sweep
    logic [15:0] dc_t;
    logic [13:0] f_n;
    logic        up_n;
    always_comb begin
        dc_t = (i_ms_tick && r_dwell_cnt != 16'hFFFF) ? r_dwell_cnt + 16'd1 : r_dwell_cnt;
        f_n  = r_hz;
        up_n = r_up;
        if (r_up) begin
            if (r_hz >= r_high || r_step >= r_high - r_hz) begin
                f_n = r_high; up_n = 1'b0;
            end else f_n = r_hz + r_step;
        end else begin
            if (r_hz <= r_base || r_step >= r_hz - r_base) begin
                f_n = r_base; up_n = 1'b1;
            end else f_n = r_hz - r_step;
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [30:0] rem_sh;
    logic        ge;
    assign rem_sh = {r_rem[29:0], r_quo[PHASE_W-1]};
    assign ge = rem_sh >= {1'b0, r_clock};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= WAVE_SINE; r_tlen <= 5'd16; r_amp <= 16'hFFFF;
            r_base <= 14'd1000; r_high <= '0; r_step <= '0; r_dwell <= '0;
            r_clock <= 30'd480000000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WAVE:  r_wave  <= i_cfg_data[2:0];
                CFG_LEN:   r_tlen  <= i_cfg_data[4:0];
                CFG_AMP:   r_amp   <= i_cfg_data[15:0];
                CFG_BASE:  r_base  <= i_cfg_data[13:0];
                CFG_HIGH:  r_high  <= i_cfg_data[13:0];
                CFG_STEP:  r_step  <= i_cfg_data[13:0];
                CFG_DWELL: r_dwell <= i_cfg_data[15:0];
                default:   r_clock <= i_cfg_data[29:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                r_user[i] <= shape_word(WAVE_TRI, 4'((i * 16) / TABLE_DEPTH));
        end else if (i_in_write && 32'(i_entry_index) < TABLE_DEPTH) begin
            r_user[IW'(i_entry_index)] <= i_entry_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lf <= CW'(len) * CW'(r_hz);
        if (!i_rst_n || i_cmd.stop) begin
            r_running <= 1'b0; r_sweeping <= 1'b0; r_up <= 1'b0; r_hz <= '0;
            r_dwell_cnt <= '0; r_phase <= '0; r_idx <= '0;
            r_busy <= 1'b0; r_div_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_div_done <= 1'b0;
            if (i_cmd.start) begin
                r_running <= 1'b1;
                r_sweeping <= r_dwell != 16'd0;
                r_up <= r_dwell != 16'd0;
                r_hz <= r_base;
                r_dwell_cnt <= '0;
                r_phase <= '0;
                r_idx <= '0;
            end
            if (i_cmd.sweep) r_el <= i_elapsed;
            if (i_cmd.sweep && r_sweeping) begin
                if (dc_t < r_dwell) r_dwell_cnt <= dc_t;
                else begin
                    r_dwell_cnt <= '0; r_hz <= f_n; r_up <= up_n;
                end
            end
            if (i_cmd.add) r_phase <= r_phase + PHASE_W'(inc);
            if (i_cmd.div_start) begin
                r_quo <= r_phase; r_rem <= '0; r_cnt <= 6'(DIV_STEPS); r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= {r_quo[PHASE_W-2:0], ge};
                r_rem <= ge ? rem_sh - {1'b0, r_clock} : rem_sh;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0; r_div_done <= 1'b1;
                end
            end
            if (r_div_done) r_phase <= PHASE_W'(r_rem);
            if (i_cmd.emit) begin
                if (32'(r_idx) + 1 >= 32'(len)) r_idx <= '0;
                else r_idx <= r_idx + IW'(1);
            end
        end
    end

    // sample word and scaling
    logic [15:0] word;
    always_comb begin
        if (r_wave <= WAVE_SAW)
            word = shape_word(r_wave, 4'((32'(r_idx) * 16) / TABLE_DEPTH));
        else
            word = r_user[r_idx];
    end

    logic [31:0] r_prod;
    logic [32:0] v;
    logic [15:0] q;
    always_ff @(posedge i_clk) r_prod <= word * r_amp;
    // v/65535 with v < 2^32: q = (v + (v>>16) + 1) >> 16 corrected
    assign v = {1'b0, r_prod} + 33'd32767;
    always_comb begin
        logic [33:0] t;
        logic [17:0] qq;
        logic [33:0] back;
        t = 34'(v) + 34'(v >> 16) + 34'd1;
        qq = 18'(t >> 16);
        back = 34'(qq) * 34'(FULL_CODE);
        if (back > 34'(v)) qq = qq - 18'd1;
        q = qq[15:0];
    end
    assign o_dac_code = q;

    logic [PHASE_W-1:0] due_full;
    logic [4:0] due;
    assign due_full = r_quo;
    always_comb begin
        due = BURST_MAX;
        if (due_full < PHASE_W'(BURST_MAX)) due = 5'(due_full);
        if (32'(due) > 32'(len)) due = 5'(len);
    end

    assign o_stat.ok = ok;
    assign o_stat.running = r_running;
    assign o_stat.div_busy = r_busy | r_div_done;
    assign o_stat.due = due;
    assign o_stat.step_ok = i_elapsed != 16'd0 && r_clock != 30'd0;
endmodule
`default_nettype wire

>>> rtl/twsg_ctrl.sv
// Controller: sequences one request through sweep, phase add, division and
// sample burst; owns the input and output handshakes. Depends on twsg_pkg.
`default_nettype none
module twsg_ctrl import twsg_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic [1:0]  i_req,
    output logic             o_in_ready,
    output logic             o_in_write,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic             o_status,
    output logic             o_last,
    output logic             o_capture,
    output t_cmd             o_cmd,
    input  wire t_stat       i_stat
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SWEEP = 4'd1;
    localparam logic [3:0] S_LF    = 4'd2;
    localparam logic [3:0] S_ADD   = 4'd3;
    localparam logic [3:0] S_DIVGO = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_PROD  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_REJ   = 4'd8;

    logic [3:0] r_state, n_state;
    logic [4:0] r_left, n_left;
    logic acc;

    assign o_in_ready = r_state == S_IDLE;
    assign acc = i_in_valid && o_in_ready;
    assign o_in_write = acc && i_req == REQ_WRITE;
    assign o_out_valid = r_state == S_OUT || r_state == S_REJ;
    assign o_status = r_state == S_REJ;
    assign o_last = r_state == S_REJ || r_left == 5'd1;
    assign o_capture = 1'b0;

    always_comb begin
        n_state = r_state;
        n_left = r_left;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_req)
                        REQ_START: begin
                            if (i_stat.ok) begin
                                o_cmd.start = 1'b1; n_left = 5'd1; n_state = S_PROD;
                            end else n_state = S_REJ;
                        end
                        REQ_STOP: o_cmd.stop = 1'b1;
                        REQ_STEP: begin
                            if (i_stat.running) begin
                                o_cmd.sweep = 1'b1;
                                if (i_stat.step_ok) n_state = S_LF;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LF:    n_state = S_ADD;
            S_ADD:   begin o_cmd.add = 1'b1; n_state = S_DIVGO; end
            S_DIVGO: begin o_cmd.div_start = 1'b1; n_state = S_DIV; end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_left = i_stat.due;
                    n_state = (i_stat.due == 5'd0) ? S_IDLE : S_PROD;
                end
            end
            S_PROD: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_left = r_left - 5'd1;
                    n_state = (r_left == 5'd1) ? S_IDLE : S_PROD;
                end
            end
            S_REJ: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_left <= '0;
        end else begin
            r_state <= n_state; r_left <= n_left;
        end
    end

    a_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_left != 5'd0) else $error("burst count zero");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> o_out_valid && i_out_ready) else $error("emit w/o item");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("overlap");
endmodule
`default_nettype wire

>>> rtl/table_waveform_sweep_generator.sv
// Top level: table waveform generator with phase accumulator and bounce sweep.
// Instantiates twsg_ctrl and twsg_datapath; depends on twsg_pkg.
//
//  channel | dir | payload
//  s_axis  | in  | tdata {entry_value, entry_index, ms_tick, elapsed}, tuser req_type
//  m_axis  | out | tdata dac_code, tuser status, tlast last_sample
//  cfg     | in  | i_cfg_we, i_cfg_index, i_cfg_data
// A time step runs sweep, phase add and a 40-step phase divider, then emits its samples.
// Start emits one sample or a reject status; stop, table write and idle step emit none.
// Output stalls hold the sample; input is taken only when the previous item is done.
// Reset is synchronous, active low.
`default_nettype none
module table_waveform_sweep_generator import twsg_pkg::*; #(
    parameter int TABLE_DEPTH     = 16,
    parameter int MAX_SAMPLE_RATE = 16000
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // elapsed, ms_tick, entry_index, entry_value
    input  wire logic [1:0]  s_axis_tuser,  // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // dac_code
    output logic             m_axis_tuser,  // status
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [29:0] i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;
    logic  in_write, cap, status;
    logic [15:0] code;

    twsg_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_req(s_axis_tuser), .o_in_ready(s_axis_tready),
        .o_in_write(in_write), .i_out_ready(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_status(status), .o_last(m_axis_tlast), .o_capture(cap),
        .o_cmd(cmd), .i_stat(stat)
    );

    twsg_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_SAMPLE_RATE(MAX_SAMPLE_RATE)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_write(in_write), .i_ms_tick(s_axis_tdata[16]),
        .i_elapsed(s_axis_tdata[15:0]), .i_entry_index(s_axis_tdata[20:17]),
        .i_entry_value(s_axis_tdata[36:21]), .i_cmd(cmd), .o_stat(stat),
        .o_dac_code(code)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = (status | cap) ? 16'd0 : code;
endmodule
`default_nettype wire

>>> sim/tb_table_waveform_sweep_generator.sv
// Testbench for table_waveform_sweep_generator: directed table plus random
// requests, checked against an in-bench predictor. Depends on twsg_pkg and the RTL.
`timescale 1ns / 1ps
module tb_table_waveform_sweep_generator;
    import twsg_pkg::*;

    localparam int DEPTH    = 16;
    localparam int MAX_RATE = 16000;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] code;
        logic        status;
        logic        last;
    } t_sample;

    typedef struct {
        logic [1:0]  req;
        logic [15:0] elapsed;
        logic        tick;
        logic [3:0]  idx;
        logic [15:0] val;
        logic        chk;
        logic [15:0] code;
        logic        status;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [29:0] i_cfg_data;

    table_waveform_sweep_generator dut (.*);

    // predictor state
    logic [2:0]  r_wave;
    logic [4:0]  r_len;
    logic [15:0] r_amp;
    logic [13:0] r_base, r_high, r_step;
    logic [15:0] r_dwell;
    logic [29:0] r_clock;
    logic        p_run, p_sweep, p_up;
    logic [13:0] p_hz;
    logic [15:0] p_dwell;
    logic [39:0] p_phase;
    logic [3:0]  p_idx;
    logic [15:0] p_user [DEPTH];

    t_sample expected_samples[$];
    t_sample pinned[$];
    int      errors;
    int      idle_pct, stall_pct;
    bit      hold_rx;
    int      quiet;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [15:0] shape_of(logic [2:0] sel, int k);
        logic [15:0] sine [16] = '{32768, 45307, 55938, 63041, 65535, 63041, 55938,
            45307, 32768, 20228, 9597, 2494, 0, 2494, 9597, 20228};
        case (sel)
            WAVE_SINE:   return sine[k];
            WAVE_TRI:    return (k == 8) ? 16'd65535 : (k < 8 ? 16'(k * 8192)
                                                            : 16'((16 - k) * 8192));
            WAVE_SQUARE: return (k >= 8) ? 16'd65535 : 16'd0;
            default:     return 16'(k * 4369);
        endcase
    endfunction

    function automatic int wave_len();
        if (r_wave <= WAVE_SAW) return DEPTH;
        if (r_len == 0) return 1;
        if (r_len > DEPTH) return DEPTH;
        return r_len;
    endfunction

    function automatic bit start_ok();
        longint n;
        if (r_wave > WAVE_USER || r_clock == 0 || r_base == 0) return 0;
        if (r_wave == WAVE_USER && (r_len == 0 || r_len > DEPTH)) return 0;
        n = wave_len();
        if (n * r_base > MAX_RATE) return 0;
        if (r_dwell != 0) begin
            if (r_high <= r_base || r_step == 0) return 0;
            if (n * r_high > MAX_RATE) return 0;
        end
        return 1;
    endfunction

    task automatic push_sample(bit last);
        logic [15:0] w;
        longint unsigned v;
        w = (r_wave <= WAVE_SAW) ? shape_of(r_wave, p_idx) : p_user[p_idx];
        v = longint'(w) * r_amp + 32767;
        expected_samples.push_back('{16'(v / 65535), 1'b0, last});
        p_idx = p_idx + 4'd1;
        if (p_idx >= wave_len()) p_idx = 4'd0;
    endtask

    task automatic clear_run();
        p_run = 1'b0; p_sweep = 1'b0; p_up = 1'b0; p_hz = '0;
        p_dwell = '0; p_phase = '0; p_idx = '0;
    endtask

    task automatic predict_item(logic [1:0] req, logic [15:0] el, logic tk,
                                logic [3:0] idx, logic [15:0] val);
        longint unsigned due, n, f;
        if (req == REQ_START) begin
            if (!start_ok()) begin
                expected_samples.push_back('{16'd0, 1'b1, 1'b1});
                return;
            end
            p_run = 1'b1; p_sweep = (r_dwell != 0); p_up = p_sweep; p_hz = r_base;
            p_dwell = '0; p_phase = '0; p_idx = '0;
            push_sample(1'b1);
        end else if (req == REQ_STOP) begin
            clear_run();
        end else if (req == REQ_WRITE) begin
            p_user[idx] = val;
        end else if (p_run) begin
            if (p_sweep) begin
                if (tk && p_dwell != 16'hFFFF) p_dwell++;
                if (p_dwell >= r_dwell) begin
                    p_dwell = '0;
                    f = p_hz;
                    if (p_up) begin
                        if (f >= r_high || r_step >= r_high - f) begin
                            f = r_high; p_up = 1'b0;
                        end else f += r_step;
                    end else begin
                        if (f <= r_base || r_step >= f - r_base) begin
                            f = r_base; p_up = 1'b1;
                        end else f -= r_step;
                    end
                    p_hz = 14'(f);
                end
            end
            if (el == 0 || r_clock == 0) return;
            n = wave_len();
            p_phase = 40'(p_phase + longint'(el) * n * p_hz);
            due = p_phase / r_clock;
            p_phase = 40'(p_phase % r_clock);
            if (due > n) due = n;
            if (due > 16) due = 16;
            for (int k = 0; k < due; k++) push_sample(k == due - 1);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [29:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WAVE:  r_wave  = v[2:0];
            CFG_LEN:   r_len   = v[4:0];
            CFG_AMP:   r_amp   = v[15:0];
            CFG_BASE:  r_base  = v[13:0];
            CFG_HIGH:  r_high  = v[13:0];
            CFG_STEP:  r_step  = v[13:0];
            CFG_DWELL: r_dwell = v[15:0];
            default:   r_clock = v;
        endcase
    endtask

    // valid stays up after an accept; the next item, an idle cycle, a register write or drain sets it
    task automatic send_item(logic [1:0] req, logic [15:0] el, logic tk,
                             logic [3:0] idx, logic [15:0] val);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {3'd0, val, idx, tk, el};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(req, el, tk, idx, val);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic random_item(bit sweepy);
        int r;
        r = $urandom_range(99);
        if (r < 6)       send_item(REQ_START, 16'($urandom), 1'($urandom), 4'($urandom),
                                   16'($urandom));
        else if (r < 8)  send_item(REQ_STOP, 16'($urandom), 1'($urandom), 4'($urandom),
                                   16'($urandom));
        else if (r < 14) send_item(REQ_WRITE, 16'($urandom), 1'($urandom), 4'($urandom),
                                   16'($urandom));
        else send_item(REQ_STEP, ($urandom_range(9) == 0) ? 16'($urandom) :
                       16'($urandom_range(sweepy ? 60000 : 3000)),
                       $urandom_range(3) != 0, 4'($urandom), 16'($urandom));
    endtask

    // output checker and stall generator
    always @(posedge i_clk) begin
        t_sample got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata, m_axis_tuser, m_axis_tlast};
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected sample actual %h", $time, got);
                    errors++;
                end else begin
                    want = expected_samples.pop_front();
                    if (pinned.size() != 0) want = pinned.pop_front();
                    if (got.code !== want.code)
                        $display("%0t: dac_code expected %h actual %h", $time,
                                 want.code, got.code);
                    if (got.status !== want.status)
                        $display("%0t: status expected %b actual %b", $time,
                                 want.status, got.status);
                    if (got.last !== want.last)
                        $display("%0t: last expected %b actual %b", $time,
                                 want.last, got.last);
                    if (got !== want) errors++;
                end
            end
            m_axis_tready <= !hold_rx && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || i_cfg_we) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > WD_LIMIT) begin
            $display("tb_table_waveform_sweep_generator: errors");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        i_rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
        m_axis_tready = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        errors = 0; idle_pct = 0; stall_pct = 0; hold_rx = 1'b0;
        r_wave = WAVE_SINE; r_len = 5'd16; r_amp = 16'hFFFF; r_base = 14'd1000;
        r_high = '0; r_step = '0; r_dwell = '0; r_clock = 30'd480000000;
        clear_run();
        for (int i = 0; i < DEPTH; i++) p_user[i] = shape_of(WAVE_TRI, i);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: a fast clock so steps emit many samples
        write_reg(CFG_CLOCK, 30'd100000);
        rows = '{
            '{REQ_STEP, 16'd500, 1'b1, 4'd0, 16'd0, 1'b0, 16'd0, 1'b0},
            '{REQ_START, 16'd0, 1'b0, 4'd0, 16'd0, 1'b1, 16'd32768, 1'b0},
            '{REQ_STEP, 16'd0, 1'b1, 4'd0, 16'd0, 1'b0, 16'd0, 1'b0},
            '{REQ_STEP, 16'd7, 1'b0, 4'd0, 16'd0, 1'b0, 16'd0, 1'b0},
            '{REQ_STEP, 16'hFFFF, 1'b1, 4'd0, 16'd0, 1'b0, 16'd0, 1'b0},
            '{REQ_STEP, 16'd100, 1'b0, 4'd0, 16'd0, 1'b0, 16'd0, 1'b0},
            '{REQ_WRITE, 16'hFFFF, 1'b1, 4'd15, 16'hFFFF, 1'b0, 16'd0, 1'b0},
            '{REQ_WRITE, 16'd0, 1'b0, 4'd0, 16'd0, 1'b0, 16'd0, 1'b0},
            '{REQ_STOP, 16'hFFFF, 1'b1, 4'd15, 16'hFFFF, 1'b0, 16'd0, 1'b0},
            '{REQ_STEP, 16'd900, 1'b1, 4'd0, 16'd0, 1'b0, 16'd0, 1'b0}};
        foreach (rows[i]) begin
            send_item(rows[i].req, rows[i].elapsed, rows[i].tick, rows[i].idx,
                      rows[i].val);
            if (rows[i].chk) pinned.push_back('{rows[i].code, rows[i].status, 1'b1});
        end
        drain();
        // bad settings reject: base at 0
        write_reg(CFG_BASE, 30'd0);
        send_item(REQ_START, '0, 1'b0, '0, '0);
        pinned.push_back('{16'd0, 1'b1, 1'b1});
        drain();
        // user table, length extremes, zero amplitude, sweep, zero clock, bad wave code
        write_reg(CFG_WAVE, 30'(WAVE_USER));
        write_reg(CFG_LEN, 30'd1);
        write_reg(CFG_AMP, 30'd0);
        write_reg(CFG_BASE, 30'd16000);
        write_reg(CFG_HIGH, 30'd16000);
        write_reg(CFG_STEP, 30'd16000);
        write_reg(CFG_DWELL, 30'hFFFF);
        send_item(REQ_START, '0, 1'b0, '0, '0);
        pinned.push_back('{16'd0, 1'b1, 1'b1});
        drain();
        write_reg(CFG_DWELL, 30'd0);
        send_item(REQ_START, '0, 1'b0, '0, '0);
        send_item(REQ_STEP, 16'hFFFF, 1'b1, '0, '0);
        drain();
        write_reg(CFG_LEN, 30'd31);
        send_item(REQ_START, '0, 1'b0, '0, '0);
        drain();
        write_reg(CFG_CLOCK, 30'd0);
        send_item(REQ_STEP, 16'd100, 1'b1, '0, '0);
        drain();
        write_reg(CFG_WAVE, 30'd7);
        send_item(REQ_START, '0, 1'b0, '0, '0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            int w;
            w = $urandom_range(4);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 68; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            write_reg(CFG_WAVE, (ph == 7) ? 30'd7 : 30'(w));
            write_reg(CFG_LEN, (ph == 5) ? 30'd16 : 30'($urandom_range(1, 16)));
            write_reg(CFG_AMP, (ph == 6) ? 30'hFFFF : 30'(16'($urandom)));
            write_reg(CFG_BASE, 30'($urandom_range(1, (ph == 2) ? 1000 : 400)));
            write_reg(CFG_HIGH, 30'($urandom_range(200, 1000)));
            write_reg(CFG_STEP, 30'($urandom_range(1, 300)));
            write_reg(CFG_DWELL, (ph % 2) ? 30'($urandom_range(1, 4)) : 30'd0);
            write_reg(CFG_CLOCK, (ph == 3) ? 30'h3FFFFFFF
                                           : 30'($urandom_range(2000, 200000)));
            send_item(REQ_START, '0, 1'b0, '0, '0);
            if (ph == 4) fork
                begin
                    hold_rx = 1'b1;
                    repeat (1500) @(posedge i_clk);
                    hold_rx = 1'b0;
                end
                repeat (20) random_item(1'b1);
            join
            repeat (55) random_item(1'(ph % 2));
            drain();
        end
        if (errors == 0) $display("tb_table_waveform_sweep_generator: clean");
        else $display("tb_table_waveform_sweep_generator: errors");
        $finish;
    end
endmodule
